/* hdl/pat_pkg.sv */
// pat_pkg: command codes, register map and bus constants for the alarm timer
// no dependencies; imported by prescaled_alarm_timer_64
package pat_pkg;

  localparam int BUS_W  = 32;
  localparam int WIDE_W = 64;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] REG_CONTROL  = 4'd0;
  localparam logic [ADDR_W-1:0] REG_CNT_LO   = 4'd1;
  localparam logic [ADDR_W-1:0] REG_CNT_HI   = 4'd2;
  localparam logic [ADDR_W-1:0] REG_UPDATE   = 4'd3;
  localparam logic [ADDR_W-1:0] REG_ALARM_LO = 4'd4;
  localparam logic [ADDR_W-1:0] REG_ALARM_HI = 4'd5;
  localparam logic [ADDR_W-1:0] REG_LOAD_LO  = 4'd6;
  localparam logic [ADDR_W-1:0] REG_LOAD_HI  = 4'd7;
  localparam logic [ADDR_W-1:0] REG_RELOAD   = 4'd8;
  localparam logic [ADDR_W-1:0] REG_INT_CLR  = 4'd9;
  localparam logic [ADDR_W-1:0] REG_INT_RAW  = 4'd10;

  // control register bit positions
  localparam int CTL_ENABLE  = 0;
  localparam int CTL_UP      = 1;
  localparam int CTL_AUTORLD = 2;
  localparam int CTL_ALARM   = 3;
  localparam int CTL_INT_EN  = 4;
  localparam int CTL_DIV_LSB = 16;

  localparam int INT_CLR_BIT = 0;

endpackage

/* hdl/prescaled_alarm_timer_64.sv */
// prescaled_alarm_timer_64: prescaled 64-bit up/down timer with alarm and autoreload
// register access and clock ticks arrive as beats on one valid/ready channel
// depends on pat_pkg
//
//  channel | direction | fields                 | handshake
//  --------+-----------+------------------------+--------------------
//  in      | input     | cmd, reg_addr, wdata   | in_valid / in_ready
//  out     | output    | rdata, irq, alarm_hit  | out_valid / out_ready
//
// a beat is held in the input register, then one pass of logic
// (64-bit step, alarm compare, register decode) updates the timer state and
// loads the result register when it is free, so out_valid rises once the beat
// leaves the input register
// with out_ready held high one beat is taken every cycle
// when the result register is full and not taken, the input register holds
// and in_ready falls once both are occupied; timer state does not move
// rst is synchronous; it empties both registers and restores the timer state
module prescaled_alarm_timer_64
  import pat_pkg::*;
#(
  parameter int COUNTER_WIDTH  = 64,
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ADDR_W-1:0]   reg_addr,
  input  logic [BUS_W-1:0]    wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BUS_W-1:0]    rdata,
  output logic                irq,
  output logic                alarm_hit
);

  localparam int CW = COUNTER_WIDTH;
  localparam int PW = PRESCALE_WIDTH;

  // input register
  logic               s1_valid;
  logic [CMD_W-1:0]   s1_cmd;
  logic [ADDR_W-1:0]  s1_addr;
  logic [BUS_W-1:0]   s1_wdata;

  // timer state
  logic [CW-1:0] count_value, count_value_next;
  logic [CW-1:0] count_latch, count_latch_next;
  logic [CW-1:0] alarm_value, alarm_value_next;
  logic [CW-1:0] load_value,  load_value_next;
  logic [PW-1:0] prescale_count, prescale_count_next;
  logic [PW-1:0] divider_setting, divider_setting_next;
  logic run_enable,  run_enable_next;
  logic count_up,    count_up_next;
  logic auto_reload, auto_reload_next;
  logic alarm_armed, alarm_armed_next;
  logic irq_enable,  irq_enable_next;
  logic irq_raw,     irq_raw_next;

  // result values for the beat in the input register
  logic [BUS_W-1:0] rdata_next;
  logic             hit_next;

  // datapath helpers
  logic [PW:0]      presc_inc;
  logic [PW:0]      period;
  logic [CW-1:0]    stepped;
  logic [WIDE_W-1:0] wide_tmp;
  logic [BUS_W-1:0]  ctl_word;

  // flow control
  logic advance;
  logic process;
  logic accept;

  assign advance  = !out_valid || out_ready;
  assign process  = s1_valid && advance;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_addr  <= reg_addr;
      s1_wdata <= wdata;
    end
  end

  // prescaler period: zero means a full wrap, one behaves as two
  always_comb begin
    if (divider_setting == '0) begin
      period = {1'b1, {PW{1'b0}}};
    end else if (divider_setting == PW'(1)) begin
      period = (PW+1)'(2);
    end else begin
      period = {1'b0, divider_setting};
    end
  end

  assign presc_inc = {1'b0, prescale_count} + (PW+1)'(1);
  assign stepped   = count_up ? count_value + CW'(1) : count_value - CW'(1);

  // control register readback
  always_comb begin
    ctl_word = '0;
    ctl_word[CTL_ENABLE]  = run_enable;
    ctl_word[CTL_UP]      = count_up;
    ctl_word[CTL_AUTORLD] = auto_reload;
    ctl_word[CTL_ALARM]   = alarm_armed;
    ctl_word[CTL_INT_EN]  = irq_enable;
    ctl_word[CTL_DIV_LSB +: PW] = divider_setting;
  end

  // one pass: state update and result for the beat in the input register
  always_comb begin
    count_value_next     = count_value;
    count_latch_next     = count_latch;
    alarm_value_next     = alarm_value;
    load_value_next      = load_value;
    prescale_count_next  = prescale_count;
    divider_setting_next = divider_setting;
    run_enable_next      = run_enable;
    count_up_next        = count_up;
    auto_reload_next     = auto_reload;
    alarm_armed_next     = alarm_armed;
    irq_enable_next      = irq_enable;
    irq_raw_next         = irq_raw;
    rdata_next           = '0;
    hit_next             = 1'b0;
    wide_tmp             = '0;

    unique case (s1_cmd)
      CMD_TICK: begin
        if (run_enable) begin
          if (presc_inc >= period) begin
            // full prescaler period: step the counter
            prescale_count_next = '0;
            count_value_next    = stepped;
            if (alarm_armed && stepped == alarm_value) begin
              hit_next         = 1'b1;
              irq_raw_next     = 1'b1;
              alarm_armed_next = 1'b0;
              if (auto_reload) begin
                count_value_next = load_value;
              end
            end
          end else begin
            prescale_count_next = presc_inc[PW-1:0];
          end
        end
      end
      CMD_WRITE: begin
        unique case (s1_addr)
          REG_CONTROL: begin
            run_enable_next      = s1_wdata[CTL_ENABLE];
            count_up_next        = s1_wdata[CTL_UP];
            auto_reload_next     = s1_wdata[CTL_AUTORLD];
            alarm_armed_next     = s1_wdata[CTL_ALARM];
            irq_enable_next      = s1_wdata[CTL_INT_EN];
            divider_setting_next = s1_wdata[CTL_DIV_LSB +: PW];
          end
          REG_UPDATE: begin
            count_latch_next = count_value;
          end
          REG_ALARM_LO, REG_ALARM_HI: begin
            wide_tmp = WIDE_W'(alarm_value);
            if (s1_addr == REG_ALARM_HI) begin
              wide_tmp[WIDE_W-1:BUS_W] = s1_wdata;
            end else begin
              wide_tmp[BUS_W-1:0] = s1_wdata;
            end
            alarm_value_next = CW'(wide_tmp);
          end
          REG_LOAD_LO, REG_LOAD_HI: begin
            wide_tmp = WIDE_W'(load_value);
            if (s1_addr == REG_LOAD_HI) begin
              wide_tmp[WIDE_W-1:BUS_W] = s1_wdata;
            end else begin
              wide_tmp[BUS_W-1:0] = s1_wdata;
            end
            load_value_next = CW'(wide_tmp);
          end
          REG_RELOAD: begin
            count_value_next = load_value;
          end
          REG_INT_CLR: begin
            if (s1_wdata[INT_CLR_BIT]) begin
              irq_raw_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        unique case (s1_addr)
          REG_CONTROL: begin
            rdata_next = ctl_word;
          end
          REG_CNT_LO, REG_CNT_HI: begin
            wide_tmp   = WIDE_W'(count_latch);
            rdata_next = (s1_addr == REG_CNT_HI) ? wide_tmp[WIDE_W-1:BUS_W]
                                                 : wide_tmp[BUS_W-1:0];
          end
          REG_ALARM_LO, REG_ALARM_HI: begin
            wide_tmp   = WIDE_W'(alarm_value);
            rdata_next = (s1_addr == REG_ALARM_HI) ? wide_tmp[WIDE_W-1:BUS_W]
                                                   : wide_tmp[BUS_W-1:0];
          end
          REG_LOAD_LO, REG_LOAD_HI: begin
            wide_tmp   = WIDE_W'(load_value);
            rdata_next = (s1_addr == REG_LOAD_HI) ? wide_tmp[WIDE_W-1:BUS_W]
                                                  : wide_tmp[BUS_W-1:0];
          end
          REG_INT_RAW: begin
            rdata_next = BUS_W'(irq_raw);
          end
          default: begin
          end
        endcase
      end
      default: begin
        // unused command code: no effect, zero read data
      end
    endcase
  end

  // timer state moves only when a beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_value     <= '0;
      count_latch     <= '0;
      alarm_value     <= '0;
      load_value      <= '0;
      prescale_count  <= '0;
      divider_setting <= PW'(2);
      run_enable      <= 1'b0;
      count_up        <= 1'b1;
      auto_reload     <= 1'b0;
      alarm_armed     <= 1'b0;
      irq_enable      <= 1'b0;
      irq_raw         <= 1'b0;
    end else if (process) begin
      count_value     <= count_value_next;
      count_latch     <= count_latch_next;
      alarm_value     <= alarm_value_next;
      load_value      <= load_value_next;
      prescale_count  <= prescale_count_next;
      divider_setting <= divider_setting_next;
      run_enable      <= run_enable_next;
      count_up        <= count_up_next;
      auto_reload     <= auto_reload_next;
      alarm_armed     <= alarm_armed_next;
      irq_enable      <= irq_enable_next;
      irq_raw         <= irq_raw_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= process || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rdata     <= rdata_next;
      irq       <= irq_raw_next && irq_enable_next;
      alarm_hit <= hit_next;
    end
  end

  // a reported alarm leaves the raw flag set and the alarm disarmed
  a_hit_sets_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_hit |-> irq_raw && !alarm_armed)
    else $error("alarm hit without raw flag set and alarm disarmed");

  // an alarm only happens on a counter step, which restarts the prescaler
  a_hit_on_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_hit |-> prescale_count == '0)
    else $error("alarm hit without prescaler restart");

  // irq in a held result matches the state it was computed from
  a_irq_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> irq == (irq_raw && irq_enable))
    else $error("irq does not match raw flag and enable");

  // a stopped timer leaves its prescaler alone
  a_stopped_presc: assert property (@(posedge clk) disable iff (rst)
    !run_enable |=> $stable(prescale_count))
    else $error("prescaler moved while timer stopped");

endmodule

/* tb/tb_prescaled_alarm_timer_64.sv */
// tb_prescaled_alarm_timer_64: self-checking bench for the prescaled 64-bit alarm timer
// a cycle-free timer predictor checks every result beat; needs pat_pkg and the timer rtl
module tb_prescaled_alarm_timer_64
  import pat_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 6;
  localparam int ITEMS      = 1300;
  // longest quiet stretch is the one long receiver hold-off plus a sender gap
  localparam int HOLD_LEN   = 300;
  localparam int HOLD_AT    = 400;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN      = 8;

  // the one command value the block does not decode
  localparam logic [CMD_W-1:0]  CMD_NONE = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [BUS_W-1:0]  wdata;
  } bus_beat_t;

  typedef struct packed {
    logic [BUS_W-1:0] rdata;
    logic             irq;
    logic             alarm_hit;
  } timer_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0]  cmd = CMD_TICK;
  logic [ADDR_W-1:0] reg_addr = REG_CONTROL;
  logic [BUS_W-1:0]  wdata = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BUS_W-1:0] rdata;
  logic irq;
  logic alarm_hit;

  bus_beat_t  beat_q[$];     // beats still to be offered
  timer_rsp_t rsp_q[$];      // results owed by the block, oldest first

  // predicted timer state
  logic [WIDE_W-1:0] cnt_q, latch_q, alarm_q, load_q;
  logic [15:0]       presc_q, div_q;
  logic              run_q, up_q, autorld_q, armed_q, inten_q, raw_q;

  int fail_cnt = 0;
  int rsp_seen = 0;
  int idle_cycles = 0;

  prescaled_alarm_timer_64 dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .reg_addr (reg_addr),
    .wdata    (wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rdata    (rdata),
    .irq      (irq),
    .alarm_hit(alarm_hit)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic reset_timer();
    cnt_q     = '0;
    latch_q   = '0;
    alarm_q   = '0;
    load_q    = '0;
    presc_q   = '0;
    div_q     = 16'd2;
    run_q     = 1'b0;
    up_q      = 1'b1;
    autorld_q = 1'b0;
    armed_q   = 1'b0;
    inten_q   = 1'b0;
    raw_q     = 1'b0;
  endtask

  // divider 0 means a full 2^16 period, divider 1 behaves as 2
  function automatic logic [16:0] tick_period(logic [15:0] d);
    if (d == 16'd0) return 17'h10000;
    if (d == 16'd1) return 17'd2;
    return {1'b0, d};
  endfunction

  // apply one accepted beat to the predicted state, return the result it owes
  function automatic timer_rsp_t advance_timer(bus_beat_t b);
    timer_rsp_t r;
    logic [16:0] nxt;
    r = '0;
    case (b.cmd)
      CMD_TICK: begin
        if (run_q) begin
          nxt = {1'b0, presc_q} + 17'd1;
          // compare against the current divider, so a lowered one fires at once
          if (nxt >= tick_period(div_q)) begin
            presc_q = '0;
            cnt_q = up_q ? cnt_q + 64'd1 : cnt_q - 64'd1;
            if (armed_q && cnt_q == alarm_q) begin
              r.alarm_hit = 1'b1;
              raw_q = 1'b1;
              armed_q = 1'b0;
              if (autorld_q) cnt_q = load_q;
            end
          end else begin
            presc_q = nxt[15:0];
          end
        end
      end
      CMD_WRITE: begin
        case (b.addr)
          REG_CONTROL: begin
            run_q     = b.wdata[CTL_ENABLE];
            up_q      = b.wdata[CTL_UP];
            autorld_q = b.wdata[CTL_AUTORLD];
            armed_q   = b.wdata[CTL_ALARM];
            inten_q   = b.wdata[CTL_INT_EN];
            div_q     = b.wdata[CTL_DIV_LSB +: 16];
          end
          REG_UPDATE:   latch_q = cnt_q;
          REG_ALARM_LO: alarm_q[31:0]  = b.wdata;
          REG_ALARM_HI: alarm_q[63:32] = b.wdata;
          REG_LOAD_LO:  load_q[31:0]   = b.wdata;
          REG_LOAD_HI:  load_q[63:32]  = b.wdata;
          REG_RELOAD:   cnt_q = load_q;
          REG_INT_CLR:  if (b.wdata[INT_CLR_BIT]) raw_q = 1'b0;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (b.addr)
          REG_CONTROL: begin
            r.rdata = '0;
            r.rdata[CTL_ENABLE]  = run_q;
            r.rdata[CTL_UP]      = up_q;
            r.rdata[CTL_AUTORLD] = autorld_q;
            r.rdata[CTL_ALARM]   = armed_q;
            r.rdata[CTL_INT_EN]  = inten_q;
            r.rdata[CTL_DIV_LSB +: 16] = div_q;
          end
          REG_CNT_LO:   r.rdata = latch_q[31:0];
          REG_CNT_HI:   r.rdata = latch_q[63:32];
          REG_ALARM_LO: r.rdata = alarm_q[31:0];
          REG_ALARM_HI: r.rdata = alarm_q[63:32];
          REG_LOAD_LO:  r.rdata = load_q[31:0];
          REG_LOAD_HI:  r.rdata = load_q[63:32];
          REG_INT_RAW:  r.rdata = {31'd0, raw_q};
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq = raw_q & inten_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a, logic [BUS_W-1:0] d);
    bus_beat_t b;
    b.cmd   = c;
    b.addr  = a;
    b.wdata = d;
    beat_q.push_back(b);
  endtask

  function automatic logic [BUS_W-1:0] ctl_word(bit en, bit up, bit ar, bit arm, bit ie,
                                                logic [15:0] dv);
    logic [BUS_W-1:0] w;
    w = '0;
    w[CTL_ENABLE]  = en;
    w[CTL_UP]      = up;
    w[CTL_AUTORLD] = ar;
    w[CTL_ALARM]   = arm;
    w[CTL_INT_EN]  = ie;
    w[CTL_DIV_LSB +: 16] = dv;
    return w;
  endfunction

  // lean toward all-zero and all-one halves so carries and borrows cross 32 bits
  function automatic logic [BUS_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k, n_ticks;
    int unsigned per;
    logic [BUS_W-1:0]  lo, hi;
    logic [WIDE_W-1:0] base, al;
    logic [15:0]       dv;
    bit up;

    // directed: reset values, top-of-range alarm with autoreload, clear behavior
    put(CMD_READ,  REG_CONTROL,  '0);
    put(CMD_READ,  REG_INT_RAW,  '0);
    put(CMD_WRITE, REG_ALARM_LO, 32'hFFFF_FFFF);
    put(CMD_WRITE, REG_ALARM_HI, 32'hFFFF_FFFF);
    put(CMD_READ,  REG_ALARM_HI, '0);
    put(CMD_WRITE, REG_LOAD_LO,  32'hFFFF_FFFE);
    put(CMD_WRITE, REG_LOAD_HI,  32'hFFFF_FFFF);
    put(CMD_WRITE, REG_RELOAD,   '0);
    // divider one counts as two
    put(CMD_WRITE, REG_CONTROL,  ctl_word(1, 1, 1, 1, 1, 16'd1));
    repeat (4) put(CMD_TICK, REG_CONTROL, '0);
    put(CMD_READ,  REG_INT_RAW,  '0);
    put(CMD_WRITE, REG_INT_CLR,  32'hFFFF_FFFE);  // bit 0 low, flag stays
    put(CMD_WRITE, REG_INT_CLR,  32'h0000_0001);
    // divider zero, then lowered mid-period so the next tick steps down
    put(CMD_WRITE, REG_CONTROL,  ctl_word(1, 0, 0, 1, 0, 16'd0));
    repeat (2) put(CMD_TICK, REG_CONTROL, '0);
    put(CMD_WRITE, REG_CONTROL,  ctl_word(1, 0, 0, 1, 1, 16'd3));
    put(CMD_TICK,  REG_CONTROL,  '0);
    put(CMD_WRITE, REG_UPDATE,   '0);
    put(CMD_READ,  REG_CNT_LO,   '0);
    put(CMD_READ,  REG_CNT_HI,   '0);
    // unused command, unused addresses, write-only register read
    put(CMD_NONE,  REG_CONTROL,  32'hFFFF_FFFF);
    put(CMD_READ,  ADDR_TOP,     '0);
    put(CMD_WRITE, 4'd12,        32'hFFFF_FFFF);
    put(CMD_READ,  REG_RELOAD,   '0);

    // random: mostly load/arm/run sequences that reach the alarm, some noise
    while (beat_q.size() < ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6))
          put(CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 15)), $urandom);
      end else begin
        lo = pick_word();
        hi = pick_word();
        base = {hi, lo};
        up = 1'($urandom_range(0, 1));
        k = $urandom_range(1, 6);
        al = up ? base + WIDE_W'(k) : base - WIDE_W'(k);
        dv = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        per = 32'(tick_period(dv));
        put(CMD_WRITE, REG_LOAD_LO,  lo);
        put(CMD_WRITE, REG_LOAD_HI,  hi);
        put(CMD_WRITE, REG_RELOAD,   $urandom);
        put(CMD_WRITE, REG_ALARM_LO, al[31:0]);
        put(CMD_WRITE, REG_ALARM_HI, al[63:32]);
        // unused control bits carry junk
        put(CMD_WRITE, REG_CONTROL,
            ctl_word(1, up, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                     1'($urandom_range(0, 1)), dv) | ($urandom & 32'h0000_FFE0));
        n_ticks = (dv == 16'd0) ? $urandom_range(1, 8)
                                : k * per + $urandom_range(0, per + 2);
        repeat (n_ticks) begin
          put(CMD_TICK, ADDR_W'($urandom_range(0, 15)), $urandom);
          if ($urandom_range(0, 7) == 0)
            put(CMD_READ, ADDR_W'($urandom_range(0, REG_INT_RAW)), $urandom);
        end
        put(CMD_WRITE, REG_UPDATE,  $urandom);
        put(CMD_READ,  REG_CNT_LO,  $urandom);
        put(CMD_READ,  REG_CNT_HI,  $urandom);
        put(CMD_READ,  REG_INT_RAW, $urandom);
        put(CMD_READ,  REG_CONTROL, $urandom);
        if ($urandom_range(0, 1) == 0) put(CMD_WRITE, REG_INT_CLR, $urandom);
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // look at the queues between edges so no driver update is half done
    do @(negedge clk);
    while (beat_q.size() != 0 || in_valid || rsp_q.size() != 0);
    repeat (DRAIN) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("** prescaled_alarm_timer_64: PASSED **");
    end else begin
      $display("** prescaled_alarm_timer_64: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    bus_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      reset_timer();
    end else begin
      // predict at acceptance, from the payload held on the port
      if (in_valid && in_ready)
        rsp_q.push_back(advance_timer('{cmd, reg_addr, wdata}));
      // payload may only move once the current beat is gone
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          nb = beat_q.pop_front();
          cmd <= nb.cmd;
          reg_addr <= nb.addr;
          wdata <= nb.wdata;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // occasional long burst gives stretches with no sender idling
            burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int hold_left = 0;
  bit hold_done = 1'b0;
  int phase_left = 0;
  int stall_mode = 0;
  logic [7:0] pat_cnt = '0;

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 8'd1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && rsp_seen >= HOLD_AT) begin
      // one long hold-off so the block backs up and drops in_ready
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(16, 160);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;                     // no stalls
        1: out_ready <= 1'($urandom_range(0, 1)); // coin flip
        default: out_ready <= pat_cnt[1:0] != 2'd0;  // one stall in four
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : check
    timer_rsp_t w;
    if (!rst && out_valid && out_ready) begin
      rsp_seen <= rsp_seen + 1;
      if (rsp_q.size() == 0) begin
        $error("result beat with nothing expected: rdata %h irq %b alarm_hit %b",
               rdata, irq, alarm_hit);
        fail_cnt++;
      end else begin
        w = rsp_q.pop_front();
        if (rdata !== w.rdata) begin
          $error("rdata: expected %h, got %h", w.rdata, rdata);
          fail_cnt++;
        end
        if (irq !== w.irq) begin
          $error("irq: expected %b, got %b", w.irq, irq);
          fail_cnt++;
        end
        if (alarm_hit !== w.alarm_hit) begin
          $error("alarm_hit: expected %b, got %b", w.alarm_hit, alarm_hit);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("** prescaled_alarm_timer_64: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
